@@ sv/lirsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lirsc_pkg: shared definitions of the resampler with soft clip
// Widths, register indexes, datapath commands and the tanh table.
// ----------------------------------------------------------------------------
`default_nettype none

package lirsc_pkg;

  localparam int TANH_ENTRIES = 256;
  localparam int TANH_HALF    = TANH_ENTRIES / 2;
  localparam int MAX_BURST    = 64;
  localparam int SAMPLE_W     = 18;
  localparam int RATIO_W      = 16;
  localparam int MODE_W       = 2;
  localparam int POS_W        = 17;
  localparam int FRAC_W       = 12;
  localparam int CNT_W        = $clog2(MAX_BURST + 1);
  localparam int TAB_W        = 31;
  localparam int IDX_W        = $clog2(TANH_ENTRIES + 1);
  localparam int SPAN_SHIFT   = 18;
  localparam int X_W          = 23;
  localparam int T_W          = 23;

  localparam logic [MODE_W-1:0] MODE_PASS     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GAIN     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESAMPLE = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_RATIO = 2'd1;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd4096;
  localparam logic [POS_W-1:0]   POS_ONE     = 17'd4096;
  localparam logic [POS_W-1:0]   MIN_STEP    = 17'd128;
  localparam logic [63:0]        ONE_Q30     = 64'd1073741824;

  // KIND_HOLD repeats the final sample of a clip through the soft clip, while
  // KIND_PASS leaves the sample untouched.
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_GAIN,
    KIND_INTERP,
    KIND_HOLD
  } kind_e;

  typedef struct packed {
    logic              load;
    logic              start;
    kind_e             kind;
    logic [FRAC_W-1:0] rel;
    logic              capture;
    logic              push;
    logic              push_marker;
    logic              final_flag;
    logic              save_prev;
    logic              clear_prev;
  } cmd_t;

  typedef struct packed {
    logic res_ready;
    logic out_free;
  } stat_t;

  typedef logic [TANH_ENTRIES:0][TAB_W-1:0] tanh_tab_t;

  // Unsigned long division by shift and subtract, used only while the table
  // is built at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, dvs}) begin
        rem    = rem - {1'b0, dvs};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series at k/(32*TANH_ENTRIES) followed by eight angle doublings, all in Q30.
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t   tab;
    logic [63:0] a, a2, a3, a5, a7, tv, den;
    tab = '0;
    for (int k = 0; k <= TANH_ENTRIES; k++) begin
      a  = udiv64((64'(k) << 25) + 64'(TANH_HALF), 64'(TANH_ENTRIES));
      a2 = (a * a) >> 30;
      a3 = (a2 * a) >> 30;
      a5 = (a3 * a2) >> 30;
      a7 = (a5 * a2) >> 30;
      tv = (a + udiv64(64'd2 * a5, 64'd15))
         - (udiv64(a3, 64'd3) + udiv64(64'd17 * a7, 64'd315));
      for (int d = 0; d < 8; d++) begin
        den = ONE_Q30 + ((tv * tv) >> 30);
        tv  = udiv64((tv << 31) + (den >> 1), den);
        if (tv > ONE_Q30) tv = ONE_Q30;
      end
      tab[k] = tv[TAB_W-1:0];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

`default_nettype wire

@@ sv/linear_interp_resampler_soft_clip.sv @@
// ----------------------------------------------------------------------------
// linear_interp_resampler_soft_clip: audio resampler with tanh soft clip
// Pass, gain with soft clip, or linear-interpolation speed change of Q2.15 audio.
// ----------------------------------------------------------------------------
// Each input word is handled alone: the block takes it, produces its results and
// only then raises s_axis_tready again. Every result runs through a six-stage
// arithmetic pipeline (one multiply for scale or interpolation, a tanh table
// lookup, one multiply for the table interpolation, a constant division), and a
// finished result may wait on m_axis_tready. Modes 0 and 1 give one result per
// input word; mode 2 gives at most 64, with positions past that cap still skipped
// one per cycle. Mode 0 passes samples unchanged; only modes 1 and 2 apply the
// soft clip. Mode 3 behaves as mode 0. The finished word sits in an output
// register, so the next computation proceeds while it waits to be taken. The
// user must write configuration through cfg_we_i, cfg_addr_i and cfg_wdata_i
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_resampler_soft_clip (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_addr_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // [17:0] sample_in, [23:18] zero
  input  wire         s_axis_tlast,   // end_of_clip
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [17:0] sample_out, [23:18] zero
  output logic        m_axis_tuser,   // sample_valid
  output logic        m_axis_tlast    // final_result
);
  import lirsc_pkg::*;

  logic [MODE_W-1:0]   mode_q;
  logic [RATIO_W-1:0]  ratio_q;
  cmd_t                cmd;
  stat_t               stat;
  logic [SAMPLE_W-1:0] m_sample;

  // Register writes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PASS;
      ratio_q <= RATIO_RESET;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_MODE) mode_q <= cfg_wdata_i[MODE_W-1:0];
      else if (cfg_addr_i == REG_RATIO) ratio_q <= cfg_wdata_i[RATIO_W-1:0];
    end
  end

  lirsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .ratio_i    (ratio_q),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  lirsc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .ratio_i    (ratio_q),
    .sample_i   (s_axis_tdata[SAMPLE_W-1:0]),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_sample_o (m_sample),
    .m_sv_o     (m_axis_tuser),
    .m_final_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(24 - SAMPLE_W){1'b0}}, m_sample};

endmodule

`default_nettype wire

@@ sv/lirsc_dp.sv @@
// ----------------------------------------------------------------------------
// lirsc_dp: arithmetic datapath and output register
// Scale or interpolate, soft clip through the tanh table, hold one pending word.
// ----------------------------------------------------------------------------
`default_nettype none

module lirsc_dp (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  lirsc_pkg::cmd_t                 cmd_i,
  output lirsc_pkg::stat_t                stat_o,
  input  wire [lirsc_pkg::RATIO_W-1:0]    ratio_i,
  input  wire [lirsc_pkg::SAMPLE_W-1:0]   sample_i,
  input  wire                             m_tready_i,
  output logic                            m_tvalid_o,
  output logic [lirsc_pkg::SAMPLE_W-1:0]  m_sample_o,
  output logic                            m_sv_o,
  output logic                            m_final_o
);
  import lirsc_pkg::*;

  localparam int PIPE = 6;

  logic signed [SAMPLE_W-1:0] s_q, prev_q;
  logic [PIPE-1:0]            vld_q;
  logic                       rdy_q;

  logic signed [SAMPLE_W:0]   a_op;
  logic signed [16:0]         b_op;
  logic signed [SAMPLE_W+11:0] base;
  logic signed [36:0]         sum;
  logic signed [X_W-1:0]      x_q;
  logic                       bypass_q;

  logic [X_W-1:0]             absx;
  logic                       big, neg;
  logic [T_W-1:0]             t;
  logic [T_W+IDX_W-1:0]       p;
  logic [T_W+IDX_W-1:0]       idx_full;
  logic                       over;
  logic [IDX_W-1:0]           idx_q;
  logic [SPAN_SHIFT-1:0]      frac_q;
  logic                       over_q, big_q, neg_q;

  logic [TAB_W-1:0]           lo_q, over2_lo;
  logic signed [31:0]         diff_q;
  logic                       over2_q, over3_q;
  logic [TAB_W-1:0]           lo3_q;
  logic signed [50:0]         prod_q;

  logic signed [33:0]         h;
  logic [31:0]                v;
  logic [14:0]                w_q;
  logic [31:0]                cw;
  logic [16:0]                mag;
  logic [SAMPLE_W-1:0]        y;
  logic [SAMPLE_W-1:0]        res_q, pend_q;

  // Operand selection: one multiplier serves every kind of result.
  always_comb begin
    a_op = {s_q[SAMPLE_W-1], s_q};
    b_op = 17'sd4096;
    base = '0;
    case (cmd_i.kind)
      KIND_GAIN: begin
        b_op = $signed({1'b0, ratio_i});
      end
      KIND_INTERP: begin
        a_op = $signed({s_q[SAMPLE_W-1], s_q}) - $signed({prev_q[SAMPLE_W-1], prev_q});
        b_op = $signed({5'd0, cmd_i.rel});
        base = $signed({prev_q, 12'd0});
      end
      default: begin
        b_op = 17'sd4096;
      end
    endcase
    sum = 37'(a_op * b_op) + 37'(base) + 37'sd2048;
  end

  always_comb begin
    neg      = x_q[X_W-1];
    absx     = neg ? X_W'(-x_q) : X_W'(x_q);
    big      = absx > X_W'(32768);
    t        = T_W'((absx - X_W'(32768)) << 1);
    p        = (T_W+IDX_W)'(t) * (T_W+IDX_W)'(TANH_ENTRIES);
    idx_full = p >> SPAN_SHIFT;
    over     = idx_full >= (T_W+IDX_W)'(TANH_ENTRIES);
    over2_lo = TANH_TAB[idx_q];
  end

  always_comb begin
    h = $signed({3'd0, lo3_q}) + 34'(prod_q >>> SPAN_SHIFT);
    if (over3_q || h > 34'sd1073741824) h = 34'sd1073741824;
    if (h < 0) h = '0;
    v   = 32'd1073741824 - 32'(h) + 32'd163840;
    cw  = 32'(w_q) * 32'd52429;
    mag = 17'd32768 - 17'(cw >> 18);
    y   = (big_q && !bypass_q) ? (neg_q ? SAMPLE_W'(-$signed({1'b0, mag})) : SAMPLE_W'(mag))
                               : x_q[SAMPLE_W-1:0];
  end

  // Payload stages; only one result is in flight, so they need no enables.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) s_q <= $signed(sample_i);
    if (cmd_i.start) begin
      x_q      <= sum[X_W+11:12];
      bypass_q <= cmd_i.kind == KIND_PASS;
    end
    idx_q   <= over ? '0 : idx_full[IDX_W-1:0];
    frac_q  <= p[SPAN_SHIFT-1:0];
    over_q  <= over;
    big_q   <= big;
    neg_q   <= neg;
    lo_q    <= over2_lo;
    diff_q  <= $signed({1'b0, TANH_TAB[idx_q + IDX_W'(1)]}) - $signed({1'b0, over2_lo});
    over2_q <= over_q;
    prod_q  <= diff_q * $signed({1'b0, frac_q});
    lo3_q   <= lo_q;
    over3_q <= over2_q;
    w_q     <= v[30:16];
    res_q   <= y;
    if (cmd_i.capture) pend_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rdy_q      <= 1'b0;
      prev_q     <= '0;
      m_tvalid_o <= 1'b0;
      m_sample_o <= '0;
      m_sv_o     <= 1'b0;
      m_final_o  <= 1'b0;
    end else begin
      vld_q <= {vld_q[PIPE-2:0], cmd_i.start};
      if (cmd_i.start) rdy_q <= 1'b0;
      else if (vld_q[PIPE-1]) rdy_q <= 1'b1;
      if (cmd_i.clear_prev) prev_q <= '0;
      else if (cmd_i.save_prev) prev_q <= s_q;
      if (cmd_i.push) begin
        m_tvalid_o <= 1'b1;
        m_sample_o <= pend_q;
        m_sv_o     <= 1'b1;
        m_final_o  <= cmd_i.final_flag;
      end else if (cmd_i.push_marker) begin
        m_tvalid_o <= 1'b1;
        m_sample_o <= '0;
        m_sv_o     <= 1'b0;
        m_final_o  <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_o <= 1'b0;
      end
    end
  end

  assign stat_o.res_ready = rdy_q;
  assign stat_o.out_free  = !m_tvalid_o || m_tready_i;

endmodule

`default_nettype wire

@@ sv/lirsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lirsc_ctrl: sequencer of the resampler
// Walks output positions for each input word and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lirsc_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [lirsc_pkg::MODE_W-1:0]  mode_i,
  input  wire [lirsc_pkg::RATIO_W-1:0] ratio_i,
  input  wire                          s_tvalid_i,
  input  wire                          s_tlast_i,
  output logic                         s_tready_o,
  output lirsc_pkg::cmd_t              cmd_o,
  input  lirsc_pkg::stat_t             stat_i
);
  import lirsc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_WAIT, S_FINISH} state_e;

  state_e           state_q, state_d;
  logic             last_q, last_d;
  logic             have_prev_q, have_prev_d;
  logic             phase_b_q, phase_b_d;
  logic             one_done_q, one_done_d;
  logic             pend_q, pend_d;
  logic [POS_W-1:0] next_pos_q, next_pos_d;
  logic [POS_W-1:0] rel_q, rel_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [POS_W-1:0] step;
  logic             resample, room;

  assign step     = ({1'b0, ratio_i} < MIN_STEP) ? MIN_STEP : {1'b0, ratio_i};
  assign resample = mode_i == MODE_RESAMPLE;
  assign room     = count_q < CNT_W'(MAX_BURST);

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    have_prev_d = have_prev_q;
    phase_b_d   = phase_b_q;
    one_done_d  = one_done_q;
    pend_d      = pend_q;
    next_pos_d  = next_pos_q;
    rel_d       = rel_q;
    count_d     = count_q;
    cmd_o       = '0;
    cmd_o.kind  = KIND_PASS;
    cmd_o.rel   = rel_q[FRAC_W-1:0];
    s_tready_o  = state_q == S_IDLE;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          last_d     = s_tlast_i;
          rel_d      = next_pos_q;
          phase_b_d  = !have_prev_q;
          one_done_d = 1'b0;
          pend_d     = 1'b0;
          count_d    = '0;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!resample) begin
          if (!one_done_q) begin
            one_done_d  = 1'b1;
            cmd_o.start = 1'b1;
            cmd_o.kind  = (mode_i == MODE_GAIN) ? KIND_GAIN : KIND_PASS;
            count_d     = count_q + CNT_W'(1);
            state_d     = S_WAIT;
          end else begin
            state_d = S_FINISH;
          end
        end else if (!phase_b_q) begin
          if (rel_q < POS_ONE) begin
            rel_d = rel_q + step;
            if (room) begin
              cmd_o.start = 1'b1;
              cmd_o.kind  = KIND_INTERP;
              count_d     = count_q + CNT_W'(1);
              state_d     = S_WAIT;
            end
          end else begin
            rel_d     = rel_q - POS_ONE;
            phase_b_d = 1'b1;
          end
        end else if (last_q && rel_q < POS_ONE) begin
          // Positions at or past the final sample repeat it through the soft clip.
          rel_d = rel_q + step;
          if (room) begin
            cmd_o.start = 1'b1;
            cmd_o.kind  = KIND_HOLD;
            count_d     = count_q + CNT_W'(1);
            state_d     = S_WAIT;
          end
        end else begin
          state_d = S_FINISH;
        end
      end
      S_WAIT: begin
        if (stat_i.res_ready && (!pend_q || stat_i.out_free)) begin
          cmd_o.push    = pend_q;
          cmd_o.capture = 1'b1;
          pend_d        = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.push        = pend_q;
          cmd_o.push_marker = last_q && !pend_q;
          cmd_o.final_flag  = last_q;
          pend_d            = 1'b0;
          if (!resample || last_q) begin
            cmd_o.clear_prev = 1'b1;
            have_prev_d      = 1'b0;
            next_pos_d       = '0;
          end else begin
            cmd_o.save_prev = 1'b1;
            have_prev_d     = 1'b1;
            next_pos_d      = rel_q;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= 1'b0;
      have_prev_q <= 1'b0;
      phase_b_q   <= 1'b0;
      one_done_q  <= 1'b0;
      pend_q      <= 1'b0;
      next_pos_q  <= '0;
      rel_q       <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      have_prev_q <= have_prev_d;
      phase_b_q   <= phase_b_d;
      one_done_q  <= one_done_d;
      pend_q      <= pend_d;
      next_pos_q  <= next_pos_d;
      rel_q       <= rel_d;
      count_q     <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_burst_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_BURST))
    else $error("burst count exceeds cap");
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push || cmd_o.push_marker) |-> stat_i.out_free)
    else $error("word pushed into a busy output register");
  a_marker_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push_marker |-> (!pend_q && count_q == '0))
    else $error("end marker sent although samples were produced");
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q)
    else $error("pending word left behind at idle");
`endif

endmodule

`default_nettype wire
